FILE: rtl/lz4_block_decoder_assert.svh
// Assertion macros for the checker of the LZ4 block decoder.
`ifndef LZ4_BLOCK_DECODER_ASSERT_SVH
`define LZ4_BLOCK_DECODER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define LZ4BD_ASSERT_IMPLY(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) \
    else $error("lz4 block decoder check failed");

// Antecedent implies consequent in the next cycle.
`define LZ4BD_ASSERT_NEXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) \
    else $error("lz4 block decoder check failed");

`endif

FILE: rtl/lz4bd_pkg.sv
`timescale 1ns / 1ps
package lz4bd_pkg;

  typedef enum logic [7:0] {
    PH_TOKEN     = 8'b0000_0001,
    PH_LIT_EXT   = 8'b0000_0010,
    PH_LITERALS  = 8'b0000_0100,
    PH_OFF_LO    = 8'b0000_1000,
    PH_OFF_HI    = 8'b0001_0000,
    PH_MATCH_EXT = 8'b0010_0000,
    PH_COPY      = 8'b0100_0000,
    PH_DONE      = 8'b1000_0000
  } phase_t;

  localparam logic       OP_BYTE = 1'b0;
  localparam logic       OP_TICK = 1'b1;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_BAD_OFFSET = 2'd1;
  localparam logic [1:0] ERR_TRUNCATED  = 2'd2;
  localparam logic [1:0] ERR_BUSY       = 2'd3;

  localparam logic [3:0] LIT_EXT_CODE   = 4'hf;
  localparam int         MATCH_EXT_MARK = 32'h0000_000f + 4;
  localparam int         MIN_MATCH      = 4;
  localparam logic [7:0] EXT_MORE       = 8'hff;

  typedef struct packed {
    logic       emit;
    logic       from_hist;
    logic [7:0] lit_byte;
    logic       last;
    logic       copy_pending;
    logic       done;
    logic [1:0] err;
  } res_t;

endpackage

FILE: rtl/lz4bd_if.sv
`timescale 1ns / 1ps
interface lz4bd_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  in_byte;
  logic        block_start;
  logic        block_end;
  logic [15:0] out_len;

  modport source (output valid, operation, in_byte, block_start, block_end, out_len,
                  input ready);
  modport sink (input valid, operation, in_byte, block_start, block_end, out_len,
                output ready);
endinterface

interface lz4bd_out_if;
  logic       valid;
  logic       ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  logic       copy_pending;
  logic       block_done;
  logic [1:0] error;

  modport source (output valid, out_valid, out_byte, out_last, copy_pending, block_done,
                  error, input ready);
  modport sink (input valid, out_valid, out_byte, out_last, copy_pending, block_done,
                error, output ready);
endinterface

FILE: rtl/lz4_block_decoder.sv
`timescale 1ns / 1ps
// LZ4 block decoder.
// item channel: one compressed byte (operation 0) or one drain tick
// (operation 1) per transfer. block_start on a byte restarts the decoder
// and takes out_len; block_end marks the block's last compressed byte.
// result channel: exactly one result per item, carrying the decoded byte
// (out_valid/out_byte), out_last, copy_pending, block_done and error.
// While copy_pending is high the producer sends ticks, one per match byte.
// A result is offered in the cycle after its item is taken.
// Throughput: one item per cycle unless stalled, bytes and ticks alike.
// Each item makes one read of the history RAM, each emitted byte one
// write at the following stage; a read hitting the entry written that
// cycle is forwarded, so overlapping copies run at one byte per cycle.
// Reset clears the parser and the result stage; the history RAM is not
// cleared, since a block only reads back what it wrote itself.
// When the receiver stalls, the result register holds and item.ready drops
// until the pending result is transferred.
module lz4_block_decoder #(
  parameter int HISTORY_DEPTH = 32768,
  parameter int LENGTH_BITS   = 20
) (
  input logic         clk,
  input logic         rst,
  lz4bd_in_if.sink    item,
  lz4bd_out_if.source result
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  lz4bd_pkg::res_t res, s2_res;
  logic [AW-1:0]   rd_addr, wr_addr, s2_waddr;
  logic            s2_valid;
  logic            fwd;
  logic [7:0]      fwd_byte;
  logic [7:0]      ram_q;
  logic [7:0]      cur_byte;
  logic            accept;
  logic            s2_write;

  assign item.ready = !s2_valid || result.ready;
  assign accept     = item.valid && item.ready;

  lz4bd_ctrl #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .LENGTH_BITS  (LENGTH_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .operation  (item.operation),
    .in_byte    (item.in_byte),
    .block_start(item.block_start),
    .block_end  (item.block_end),
    .out_len    (item.out_len),
    .res        (res),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr)
  );

  assign cur_byte = s2_res.from_hist ? (fwd ? fwd_byte : ram_q) : s2_res.lit_byte;
  assign s2_write = s2_valid && s2_res.emit && result.ready;

  lz4bd_ram #(
    .WIDTH(8),
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (s2_write),
    .waddr(s2_waddr),
    .wdata(cur_byte),
    .re   (accept),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (accept) begin
      s2_valid <= 1'b1;
    end else if (result.ready) begin
      s2_valid <= 1'b0;
    end
  end

  // Forward the byte written in the same cycle as the read of its entry.
  always_ff @(posedge clk) begin
    if (accept) begin
      s2_res   <= res;
      s2_waddr <= wr_addr;
      fwd      <= s2_write && (s2_waddr == rd_addr);
      fwd_byte <= cur_byte;
    end
  end

  assign result.valid        = s2_valid;
  assign result.out_valid    = s2_res.emit;
  assign result.out_byte     = s2_res.emit ? cur_byte : 8'd0;
  assign result.out_last     = s2_res.last;
  assign result.copy_pending = s2_res.copy_pending;
  assign result.block_done   = s2_res.done;
  assign result.error        = s2_res.err;

endmodule

FILE: rtl/lz4bd_ram.sv
`timescale 1ns / 1ps
module lz4bd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/lz4bd_ctrl.sv
`timescale 1ns / 1ps
module lz4bd_ctrl #(
  parameter int HISTORY_DEPTH = 32768,
  parameter int LENGTH_BITS   = 20
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic                             operation,
  input  logic [7:0]                       in_byte,
  input  logic                             block_start,
  input  logic                             block_end,
  input  logic [15:0]                      out_len,
  output lz4bd_pkg::res_t                  res,
  output logic [$clog2(HISTORY_DEPTH)-1:0] rd_addr,
  output logic [$clog2(HISTORY_DEPTH)-1:0] wr_addr
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int TW = 17;
  localparam int LB = LENGTH_BITS;

  lz4bd_pkg::phase_t phase, phase_next;
  logic [15:0]   produced, produced_next;
  logic [TW-1:0] target_len, target_len_next;
  logic [LB-1:0] literal_left, literal_left_next;
  logic [LB-1:0] match_left, match_left_next;
  logic [7:0]    offset_low, offset_low_next;
  logic [AW-1:0] copy_source, copy_source_next;
  logic [1:0]    error_latch, error_latch_next;
  logic          input_ended, input_ended_next;
  logic          offset_bad, offset_bad_next;

  function automatic logic [LB-1:0] sat_add(logic [LB-1:0] a, logic [7:0] b);
    logic [LB:0] s;
    s = {1'b0, a} + {{(LB - 7){1'b0}}, b};
    return s[LB] ? {LB{1'b1}} : s[LB-1:0];
  endfunction

  always_comb begin
    logic [15:0] off;
    logic [15:0] diff;
    logic        bad;
    logic        full;
    phase_next        = phase;
    produced_next     = produced;
    target_len_next   = target_len;
    literal_left_next = literal_left;
    match_left_next   = match_left;
    offset_low_next   = offset_low;
    copy_source_next  = copy_source;
    error_latch_next  = error_latch;
    input_ended_next  = input_ended;
    offset_bad_next   = offset_bad;
    res               = '0;
    res.lit_byte      = in_byte;
    off               = {in_byte, offset_low};
    diff              = '0;
    bad               = 1'b0;
    full              = 1'b0;

    if (operation == lz4bd_pkg::OP_TICK) begin
      if (phase == lz4bd_pkg::PH_COPY) begin
        res.emit         = 1'b1;
        res.from_hist    = 1'b1;
        copy_source_next = copy_source + 1'b1;
        match_left_next  = (match_left != '0) ? match_left - 1'b1 : '0;
        produced_next    = produced + 16'd1;
        if ({1'b0, produced_next} >= target_len) begin
          res.last   = 1'b1;
          phase_next = lz4bd_pkg::PH_DONE;
        end else if (match_left_next == '0) begin
          if (input_ended) begin
            if (error_latch == lz4bd_pkg::ERR_NONE) begin
              error_latch_next = lz4bd_pkg::ERR_TRUNCATED;
            end
            phase_next = lz4bd_pkg::PH_DONE;
          end else begin
            phase_next = lz4bd_pkg::PH_TOKEN;
          end
        end
      end
    end else begin
      if (block_start) begin
        phase_next        = lz4bd_pkg::PH_TOKEN;
        produced_next     = '0;
        target_len_next   = ({1'b0, out_len} > TW'(HISTORY_DEPTH)) ? TW'(HISTORY_DEPTH)
                                                                  : {1'b0, out_len};
        literal_left_next = '0;
        match_left_next   = '0;
        offset_low_next   = '0;
        copy_source_next  = '0;
        error_latch_next  = lz4bd_pkg::ERR_NONE;
        input_ended_next  = 1'b0;
        offset_bad_next   = 1'b0;
      end
      off = {in_byte, offset_low_next};
      if (phase_next == lz4bd_pkg::PH_COPY) begin
        if (error_latch_next == lz4bd_pkg::ERR_NONE) begin
          error_latch_next = lz4bd_pkg::ERR_BUSY;
        end
        phase_next = lz4bd_pkg::PH_DONE;
      end else if (phase_next != lz4bd_pkg::PH_DONE) begin
        full = {1'b0, produced_next} >= target_len_next;
        if (full) begin
          phase_next = lz4bd_pkg::PH_DONE;
        end else begin
          unique case (phase_next)
            lz4bd_pkg::PH_TOKEN: begin
              literal_left_next = LB'(in_byte[7:4]);
              match_left_next   = LB'(in_byte[3:0]) + LB'(lz4bd_pkg::MIN_MATCH);
              if (in_byte[7:4] == lz4bd_pkg::LIT_EXT_CODE) begin
                phase_next = lz4bd_pkg::PH_LIT_EXT;
              end else if (in_byte[7:4] != 4'd0) begin
                phase_next = lz4bd_pkg::PH_LITERALS;
              end else begin
                phase_next = lz4bd_pkg::PH_OFF_LO;
              end
            end
            lz4bd_pkg::PH_LIT_EXT: begin
              literal_left_next = sat_add(literal_left_next, in_byte);
              if (in_byte != lz4bd_pkg::EXT_MORE) begin
                phase_next = lz4bd_pkg::PH_LITERALS;
              end
            end
            lz4bd_pkg::PH_LITERALS: begin
              literal_left_next = (literal_left_next != '0) ? literal_left_next - 1'b1 : '0;
              phase_next = (literal_left_next != '0) ? lz4bd_pkg::PH_LITERALS
                                                     : lz4bd_pkg::PH_OFF_LO;
              res.emit      = 1'b1;
              produced_next = produced_next + 16'd1;
              if ({1'b0, produced_next} >= target_len_next) begin
                res.last   = 1'b1;
                phase_next = lz4bd_pkg::PH_DONE;
              end
            end
            lz4bd_pkg::PH_OFF_LO: begin
              offset_low_next = in_byte;
              phase_next      = lz4bd_pkg::PH_OFF_HI;
            end
            lz4bd_pkg::PH_OFF_HI: begin
              bad              = (off == 16'd0) || (off > produced_next);
              diff             = produced_next - off;
              offset_bad_next  = bad;
              copy_source_next = bad ? '0 : diff[AW-1:0];
              if (match_left_next == LB'(lz4bd_pkg::MATCH_EXT_MARK)) begin
                phase_next = lz4bd_pkg::PH_MATCH_EXT;
              end else if (bad) begin
                if (error_latch_next == lz4bd_pkg::ERR_NONE) begin
                  error_latch_next = lz4bd_pkg::ERR_BAD_OFFSET;
                end
                phase_next = lz4bd_pkg::PH_DONE;
              end else begin
                phase_next = lz4bd_pkg::PH_COPY;
              end
            end
            lz4bd_pkg::PH_MATCH_EXT: begin
              match_left_next = sat_add(match_left_next, in_byte);
              if (in_byte != lz4bd_pkg::EXT_MORE) begin
                if (offset_bad_next) begin
                  if (error_latch_next == lz4bd_pkg::ERR_NONE) begin
                    error_latch_next = lz4bd_pkg::ERR_BAD_OFFSET;
                  end
                  phase_next = lz4bd_pkg::PH_DONE;
                end else begin
                  phase_next = lz4bd_pkg::PH_COPY;
                end
              end
            end
            default: begin
            end
          endcase
        end
        if (block_end) begin
          if (phase_next == lz4bd_pkg::PH_COPY) begin
            input_ended_next = 1'b1;
          end else if (phase_next != lz4bd_pkg::PH_DONE) begin
            if (error_latch_next == lz4bd_pkg::ERR_NONE) begin
              error_latch_next = lz4bd_pkg::ERR_TRUNCATED;
            end
            phase_next = lz4bd_pkg::PH_DONE;
          end
        end
      end
    end

    res.copy_pending = phase_next == lz4bd_pkg::PH_COPY;
    res.done         = phase_next == lz4bd_pkg::PH_DONE;
    res.err          = error_latch_next;
  end

  // Literals write at the count before it advances; ticks too, since a
  // tick never starts a block.
  assign rd_addr = copy_source;
  assign wr_addr = (operation == lz4bd_pkg::OP_BYTE && block_start) ? '0 : produced[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= lz4bd_pkg::PH_TOKEN;
      produced     <= '0;
      target_len   <= '0;
      literal_left <= '0;
      match_left   <= '0;
      offset_low   <= '0;
      copy_source  <= '0;
      error_latch  <= lz4bd_pkg::ERR_NONE;
      input_ended  <= 1'b0;
      offset_bad   <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      produced     <= produced_next;
      target_len   <= target_len_next;
      literal_left <= literal_left_next;
      match_left   <= match_left_next;
      offset_low   <= offset_low_next;
      copy_source  <= copy_source_next;
      error_latch  <= error_latch_next;
      input_ended  <= input_ended_next;
      offset_bad   <= offset_bad_next;
    end
  end

endmodule

FILE: rtl/lz4bd_checker.sv
`timescale 1ns / 1ps
`include "lz4_block_decoder_assert.svh"
module lz4bd_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic       out_valid,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       copy_pending,
  input logic       block_done,
  input logic [1:0] error
);

  `LZ4BD_ASSERT_NEXT(a_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(out_byte))
  `LZ4BD_ASSERT_IMPLY(a_idle_zero, clk, rst, res_valid && !out_valid, out_byte == 8'd0)
  `LZ4BD_ASSERT_IMPLY(a_last_done, clk, rst, res_valid && out_last, out_valid && block_done)
  `LZ4BD_ASSERT_IMPLY(a_err_done, clk, rst, res_valid && error != lz4bd_pkg::ERR_NONE, block_done)
  `LZ4BD_ASSERT_IMPLY(a_pend_live, clk, rst, res_valid && copy_pending, !block_done)

endmodule

bind lz4_block_decoder lz4bd_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .out_valid   (result.out_valid),
  .out_byte    (result.out_byte),
  .out_last    (result.out_last),
  .copy_pending(result.copy_pending),
  .block_done  (result.block_done),
  .error       (result.error)
);
